### hdl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, codes and default sizes of the banker's safety check unit.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // Default sizes handed to the top level parameters
    localparam int MAX_PROCESSES_DEF = 8;
    localparam int MAX_RESOURCES_DEF = 4;
    localparam int AMOUNT_BITS_DEF   = 8;

    // Fixed port field types
    typedef logic [1:0] t_kind;
    typedef logic [2:0] t_pidx_in;
    typedef logic [1:0] t_ridx_in;
    typedef logic [7:0] t_amount_in;
    typedef logic [2:0] t_pid;
    typedef logic [3:0] t_cfg_data;
    typedef logic [0:0] t_cfg_index;
    typedef logic [3:0] t_process_count;
    typedef logic [2:0] t_resource_count;

    // Entry kind codes
    localparam t_kind KIND_FREE  = 2'd0;
    localparam t_kind KIND_HELD  = 2'd1;
    localparam t_kind KIND_CLAIM = 2'd2;

    // Configuration register indexes
    localparam t_cfg_index CFG_PROCESS_COUNT  = 1'd0;
    localparam t_cfg_index CFG_RESOURCE_COUNT = 1'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic init;
        logic next_proc;
        logic read;
        logic eval;
        logic commit;
        logic emit_unsafe;
        logic emit_order;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic all_done;
        logic proc_finished;
        logic last_proc;
        logic last_res;
        logic fit;
    } t_dp_status;

endpackage

### hdl/bsc_ctrl.sv
// ----------------------------------------------------------------------------
// bsc_ctrl
// Sequencer of the safety check: walks processes and resources, decides
// commits and emission.
// ----------------------------------------------------------------------------
module bsc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_start_check,
    input  bsc_pkg::t_dp_status  i_status,
    output bsc_pkg::t_dp_cmd     o_cmd,
    output logic                 o_busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INIT   = 3'd1;
    localparam logic [2:0] S_PROC   = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_EVAL   = 3'd4;
    localparam logic [2:0] S_DECIDE = 3'd5;
    localparam logic [2:0] S_FAIL   = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_start_check) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_PROC;
            end
            S_PROC: begin
                if (i_status.all_done) begin
                    n_state = S_EMIT;
                end else if (i_status.proc_finished) begin
                    if (i_status.last_proc) begin
                        n_state = S_FAIL;
                    end else begin
                        o_cmd.next_proc = 1'b1;
                    end
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_status.last_res ? S_DECIDE : S_READ;
            end
            S_DECIDE: begin
                if (i_status.fit) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_PROC;
                end else if (i_status.last_proc) begin
                    n_state = S_FAIL;
                end else begin
                    o_cmd.next_proc = 1'b1;
                    n_state         = S_PROC;
                end
            end
            S_FAIL: begin
                o_cmd.emit_unsafe = 1'b1;
                n_state           = S_IDLE;
            end
            S_EMIT: begin
                o_cmd.emit_order = 1'b1;
                if (i_status.last_proc) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### hdl/bsc_datapath.sv
// ----------------------------------------------------------------------------
// bsc_datapath
// Tables, free pool, working pool, finish flags, safe order and result
// registers of the safety check.
// ----------------------------------------------------------------------------
module bsc_datapath #(
    parameter int MAX_PROCESSES = bsc_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = bsc_pkg::MAX_RESOURCES_DEF,
    parameter int AMOUNT_BITS   = bsc_pkg::AMOUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  bsc_pkg::t_cfg_index   i_cfg_index,
    input  bsc_pkg::t_cfg_data    i_cfg_data,
    input  bsc_pkg::t_kind        i_kind,
    input  bsc_pkg::t_pidx_in     i_process_index,
    input  bsc_pkg::t_ridx_in     i_resource_index,
    input  bsc_pkg::t_amount_in   i_amount,
    input  bsc_pkg::t_dp_cmd      i_cmd,
    output bsc_pkg::t_dp_status   o_status,
    output logic                  o_valid,
    output bsc_pkg::t_pid         o_process_id,
    output logic                  o_safe,
    output logic                  o_last
);

    localparam int TABLE_DEPTH = MAX_PROCESSES * MAX_RESOURCES;
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PIDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RIDX_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int PCNT_W = $clog2(MAX_PROCESSES + 1);
    localparam int RCNT_W = $clog2(MAX_RESOURCES + 1);
    localparam int WORK_W = AMOUNT_BITS + $clog2(MAX_PROCESSES + 1) + 1;
    localparam int CMP_W  = WORK_W + 1;

    // Configuration
    bsc_pkg::t_process_count  r_process_count;
    bsc_pkg::t_resource_count r_resource_count;
    logic [PCNT_W-1:0]        w_nproc;
    logic [RCNT_W-1:0]        w_nres;

    // Storage
    logic [AMOUNT_BITS-1:0] held_mem  [TABLE_DEPTH];
    logic [AMOUNT_BITS-1:0] claim_mem [TABLE_DEPTH];
    logic [AMOUNT_BITS-1:0] r_held_q;
    logic [AMOUNT_BITS-1:0] r_claim_q;
    logic [AMOUNT_BITS-1:0] r_free    [MAX_RESOURCES];
    logic [WORK_W-1:0]      r_work    [MAX_RESOURCES];
    logic [AMOUNT_BITS-1:0] r_buf     [MAX_RESOURCES];
    logic [MAX_PROCESSES-1:0] r_finished;
    logic [PIDX_W-1:0]      r_order   [MAX_PROCESSES];

    // Walk counters
    logic [PIDX_W-1:0] r_p;
    logic [RIDX_W-1:0] r_r;
    logic [PCNT_W-1:0] r_done;
    logic              r_fit;

    logic                   w_ridx_ok;
    logic                   w_pidx_ok;
    logic [ADDR_W-1:0]      w_load_addr;
    logic [ADDR_W-1:0]      w_walk_addr;
    logic [AMOUNT_BITS-1:0] w_amount;
    logic                   w_res_fits;

    // Clamp counts into 1..max
    always_comb begin
        if (r_process_count == '0) begin
            w_nproc = PCNT_W'(1);
        end else if (32'(r_process_count) > 32'(MAX_PROCESSES)) begin
            w_nproc = PCNT_W'(MAX_PROCESSES);
        end else begin
            w_nproc = PCNT_W'(r_process_count);
        end
        if (r_resource_count == '0) begin
            w_nres = RCNT_W'(1);
        end else if (32'(r_resource_count) > 32'(MAX_RESOURCES)) begin
            w_nres = RCNT_W'(MAX_RESOURCES);
        end else begin
            w_nres = RCNT_W'(r_resource_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_process_count  <= bsc_pkg::t_process_count'(5);
            r_resource_count <= bsc_pkg::t_resource_count'(3);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bsc_pkg::CFG_PROCESS_COUNT: begin
                    r_process_count <= i_cfg_data;
                end
                bsc_pkg::CFG_RESOURCE_COUNT: begin
                    r_resource_count <= bsc_pkg::t_resource_count'(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    assign w_ridx_ok   = 32'(i_resource_index) < 32'(MAX_RESOURCES);
    assign w_pidx_ok   = 32'(i_process_index) < 32'(MAX_PROCESSES);
    assign w_amount    = AMOUNT_BITS'(i_amount);
    assign w_load_addr = ADDR_W'(32'(i_process_index) * MAX_RESOURCES
                                 + 32'(i_resource_index));
    assign w_walk_addr = ADDR_W'(32'(r_p) * MAX_RESOURCES + 32'(r_r));

    // Table memories: one write port for loading, one registered read for the walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_ridx_ok && w_pidx_ok) begin
            if (i_kind == bsc_pkg::KIND_HELD) begin
                held_mem[w_load_addr] <= w_amount;
            end
            if (i_kind == bsc_pkg::KIND_CLAIM) begin
                claim_mem[w_load_addr] <= w_amount;
            end
        end
        if (i_cmd.read) begin
            r_held_q  <= held_mem[w_walk_addr];
            r_claim_q <= claim_mem[w_walk_addr];
        end
    end

    // Free pool
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_RESOURCES; i++) begin
                r_free[i] <= '0;
            end
        end else if (i_cmd.load && w_ridx_ok && (i_kind == bsc_pkg::KIND_FREE)) begin
            r_free[i_resource_index[RIDX_W-1:0]] <= w_amount;
        end
    end

    // need <= work  <=>  claim <= held + work
    assign w_res_fits = (CMP_W'(r_held_q) + CMP_W'(r_work[r_r])) >= CMP_W'(r_claim_q);

    // Working pool and held buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            for (int i = 0; i < MAX_RESOURCES; i++) begin
                r_work[i] <= WORK_W'(r_free[i]);
            end
        end else if (i_cmd.commit) begin
            for (int i = 0; i < MAX_RESOURCES; i++) begin
                if (i < int'(w_nres)) begin
                    r_work[i] <= r_work[i] + WORK_W'(r_buf[i]);
                end
            end
        end
        if (i_cmd.eval) begin
            r_buf[r_r] <= r_held_q;
        end
        if (i_cmd.commit) begin
            r_order[r_done[PIDX_W-1:0]] <= r_p;
        end
    end

    // Walk control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_finished <= '0;
            r_p        <= '0;
            r_r        <= '0;
            r_done     <= '0;
            r_fit      <= 1'b1;
        end else begin
            if (i_cmd.init) begin
                r_finished <= '0;
                r_p        <= '0;
                r_r        <= '0;
                r_done     <= '0;
                r_fit      <= 1'b1;
            end
            if (i_cmd.eval) begin
                r_fit <= r_fit & w_res_fits;
                if (!o_status.last_res) begin
                    r_r <= r_r + RIDX_W'(1);
                end
            end
            if (i_cmd.commit) begin
                r_finished[r_p] <= 1'b1;
                r_done          <= r_done + PCNT_W'(1);
                r_p             <= '0;
                r_r             <= '0;
                r_fit           <= 1'b1;
            end
            if (i_cmd.next_proc) begin
                r_p   <= r_p + PIDX_W'(1);
                r_r   <= '0;
                r_fit <= 1'b1;
            end
            if (i_cmd.emit_order && !o_status.last_proc) begin
                r_p <= r_p + PIDX_W'(1);
            end
        end
    end

    assign o_status.all_done      = (r_done == w_nproc);
    assign o_status.proc_finished = r_finished[r_p];
    assign o_status.last_proc     = ((PCNT_W'(r_p) + PCNT_W'(1)) == w_nproc);
    assign o_status.last_res      = ((RCNT_W'(r_r) + RCNT_W'(1)) == w_nres);
    assign o_status.fit           = r_fit;

    // Result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit_unsafe | i_cmd.emit_order;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_unsafe) begin
            o_process_id <= '0;
            o_safe       <= 1'b0;
            o_last       <= 1'b1;
        end else if (i_cmd.emit_order) begin
            o_process_id <= bsc_pkg::t_pid'(r_order[r_p]);
            o_safe       <= 1'b1;
            o_last       <= o_status.last_proc;
        end
    end

endmodule

### hdl/bankers_safety_check_unit.sv
// ----------------------------------------------------------------------------
// bankers_safety_check_unit
// Banker's algorithm safety check over tables loaded one entry at a time.
// ----------------------------------------------------------------------------
// Loading takes one entry per cycle: while o_busy is low every cycle with
// i_start high stores one free pool, held or claim entry if its indexes
// are in range. An entry with i_start_check set is stored and then starts
// the check; o_busy stays high until the last result has been issued. The
// check walks processes in order through one shared comparator fed by the
// registered read of the two table memories: each unfinished process
// visited is checked resource by resource and then decided, each finished
// one is skipped, and a round restarts the walk at process 0. A safe state
// then streams process_count results back to back; an unsafe state gives
// one result. Results appear on o_valid for exactly one cycle each and
// there is no back-pressure: the receiver must take every result when it
// shows.
// ----------------------------------------------------------------------------
module bankers_safety_check_unit #(
    parameter int MAX_PROCESSES = bsc_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = bsc_pkg::MAX_RESOURCES_DEF,
    parameter int AMOUNT_BITS   = bsc_pkg::AMOUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  bsc_pkg::t_cfg_index  i_cfg_index,
    input  bsc_pkg::t_cfg_data   i_cfg_data,
    // command channel
    input  logic                 i_start,
    output logic                 o_busy,
    input  bsc_pkg::t_kind       i_kind,
    input  bsc_pkg::t_pidx_in    i_process_index,
    input  bsc_pkg::t_ridx_in    i_resource_index,
    input  bsc_pkg::t_amount_in  i_amount,
    input  logic                 i_start_check,
    // result channel
    output logic                 o_valid,
    output bsc_pkg::t_pid        o_process_id,
    output logic                 o_safe,
    output logic                 o_last
);

    bsc_pkg::t_dp_cmd    w_cmd;
    bsc_pkg::t_dp_status w_status;

    // Sequencer: accept transactions while idle, then run the walk
    bsc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_start_check (i_start_check),
        .i_status      (w_status),
        .o_cmd         (w_cmd),
        .o_busy        (o_busy)
    );

    // Storage, working pool, comparator and result registers
    bsc_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES),
        .AMOUNT_BITS   (AMOUNT_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_kind),
        .i_process_index  (i_process_index),
        .i_resource_index (i_resource_index),
        .i_amount         (i_amount),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_valid          (o_valid),
        .o_process_id     (o_process_id),
        .o_safe           (o_safe),
        .o_last           (o_last)
    );

endmodule

### hdl/bsc_checker.sv
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks of the banker's safety check unit.
// ----------------------------------------------------------------------------
module bsc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input logic          i_start_check,
    input logic          o_busy,
    input logic          o_valid,
    input bsc_pkg::t_pid o_process_id,
    input logic          o_safe,
    input logic          o_last
);

    // An unsafe verdict is a single result with process 0
    a_unsafe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_safe) |-> (o_last && (o_process_id == '0)))
        else $error("unsafe result not final or carries a process id");

    // A started check keeps the unit busy
    a_check_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_start_check) |=> o_busy)
        else $error("check started but unit not busy");

    // Results of one check come back to back until the final one
    a_result_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> (o_valid && o_safe))
        else $error("gap inside a safe order burst");

    // Every result follows a busy cycle
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result without preceding check");

endmodule

bind bankers_safety_check_unit bsc_checker u_bsc_checker (.*);
